FILE: hw/rtl/adts_pkg.sv
// ----------------------------------------------------------------------------
// ADTS deframer package
// Shared widths, constants, phase type and the sample rate lookup.
// ----------------------------------------------------------------------------
package adts_pkg;

    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 13;
    localparam int RATE_W       = 17;
    localparam int HEADER_BYTES = 7;

    localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_MASK   = 8'hF0;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST = 13'd518;
    localparam logic [LEN_W-1:0]  FIRST_BODY  = 13'd2;
    localparam logic [LEN_W-1:0]  LAST_HDR    = 13'd6;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_FRAME
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              frame_start;
        logic              frame_end;
        logic              length_error;
        logic [1:0]        profile;
        logic [3:0]        rate_index;
        logic [RATE_W-1:0] sample_rate;
        logic [2:0]        channels;
        logic              crc_absent;
        logic [LEN_W-1:0]  frame_length;
        logic [10:0]       buffer_fullness;
        logic [1:0]        raw_blocks;
    } result_t;

    function automatic logic [RATE_W-1:0] rate_of(input logic [3:0] idx);
        logic [RATE_W-1:0] r;
        case (idx)
            4'd0:    r = 17'd96000;
            4'd1:    r = 17'd88200;
            4'd2:    r = 17'd64000;
            4'd3:    r = 17'd48000;
            4'd4:    r = 17'd44100;
            4'd5:    r = 17'd32000;
            4'd6:    r = 17'd24000;
            4'd7:    r = 17'd22050;
            4'd8:    r = 17'd16000;
            4'd9:    r = 17'd12000;
            4'd10:   r = 17'd11025;
            4'd11:   r = 17'd8000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/adts_if.sv
// ----------------------------------------------------------------------------
// ADTS deframer channels
// Byte stream, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface adts_stream_if;
    import adts_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    modport source  (output valid, in_byte, input ready);
    modport sink    (input valid, in_byte, output ready);
    modport monitor (input valid, ready, in_byte);
endinterface

interface adts_result_if;
    import adts_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_start;
    logic              frame_end;
    logic              length_error;
    logic [1:0]        profile;
    logic [3:0]        rate_index;
    logic [RATE_W-1:0] sample_rate;
    logic [2:0]        channels;
    logic              crc_absent;
    logic [LEN_W-1:0]  frame_length;
    logic [10:0]       buffer_fullness;
    logic [1:0]        raw_blocks;
    modport source (output valid, out_byte, frame_start, frame_end, length_error, profile,
                    rate_index, sample_rate, channels, crc_absent, frame_length,
                    buffer_fullness, raw_blocks, input ready);
    modport sink   (input valid, out_byte, frame_start, frame_end, length_error, profile,
                    rate_index, sample_rate, channels, crc_absent, frame_length,
                    buffer_fullness, raw_blocks, output ready);
    modport monitor (input valid, ready, out_byte, frame_start, frame_end, length_error,
                     profile, rate_index, sample_rate, channels, crc_absent, frame_length,
                     buffer_fullness, raw_blocks);
endinterface

interface adts_cfg_if;
    import adts_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] max_frame_length;
    modport source  (output valid, max_frame_length, input ready);
    modport sink    (input valid, max_frame_length, output ready);
    modport monitor (input valid, ready, max_frame_length);
endinterface

FILE: hw/rtl/adts_frame_deframer.sv
// ----------------------------------------------------------------------------
// ADTS frame deframer
// Hunts for the 0xFFF syncword, passes each frame through with start/end
// marks and presents the decoded header fields on the last word.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                     | note
//  stream   | in  | in_byte                     | one stream word per accept
//  result   | out | out_byte, marks, header     | one word later than input
//  cfg      | in  | max_frame_length            | always ready
//
//  One word per cycle unless stalled: state and result register in one pass.
//  A frame word leaves on the accept of the following word.
//  Reset: hunting, max_frame_length = 518, result empty.
//  stream.ready drops only while a held result is not taken.
// ----------------------------------------------------------------------------
module adts_frame_deframer (
    input  logic            clk,
    input  logic            rst_n,
    adts_stream_if.sink     stream,
    adts_result_if.source   result,
    adts_cfg_if.sink        cfg
);
    import adts_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] last_byte_reg, last_byte_next;
    logic [LEN_W-1:0]  byte_count_reg, byte_count_next;
    logic [LEN_W-1:0]  total_length_reg, total_length_next;
    logic [LEN_W-1:0]  max_len_reg;
    logic [BYTE_W-1:0] hdr_reg [1:6];
    logic              res_valid_reg;
    result_t           res_reg, res_next;

    logic              accept;
    logic              emit;
    logic              hdr_we;
    logic [2:0]        hdr_idx;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] h6;
    logic [LEN_W-1:0]  dec_len;
    logic              put_fields;

    assign stream.ready = !res_valid_reg || result.ready;
    assign accept       = stream.valid && stream.ready;
    assign cfg.ready    = 1'b1;
    assign b            = stream.in_byte;

    assign dec_len = {hdr_reg[3][1:0], hdr_reg[4], hdr_reg[5][7:5]};
    assign h6      = (byte_count_reg == LAST_HDR) ? b : hdr_reg[6];

    always_comb
    begin
        phase_next        = phase_reg;
        last_byte_next    = last_byte_reg;
        byte_count_next   = byte_count_reg;
        total_length_next = total_length_reg;
        emit              = 1'b0;
        hdr_we            = 1'b0;
        hdr_idx           = byte_count_reg[2:0];
        put_fields        = 1'b0;
        res_next          = '0;
        if (accept)
        begin
            last_byte_next = b;
            case (phase_reg)
                PH_FRAME:
                begin
                    emit              = 1'b1;
                    res_next.out_byte = last_byte_reg;
                    hdr_we            = (byte_count_reg < 13'(HEADER_BYTES));
                    byte_count_next   = byte_count_reg + 13'd1;
                    if (byte_count_reg == LAST_HDR)
                    begin
                        total_length_next = dec_len;
                        if (dec_len < 13'(HEADER_BYTES) || dec_len > max_len_reg)
                        begin
                            res_next.frame_end    = 1'b1;
                            res_next.length_error = 1'b1;
                            put_fields            = 1'b1;
                            phase_next            = PH_HUNT;
                            byte_count_next       = '0;
                        end
                    end
                    else if (byte_count_reg >= 13'(HEADER_BYTES) &&
                             byte_count_reg >= total_length_reg)
                    begin
                        res_next.frame_end = 1'b1;
                        put_fields         = 1'b1;
                        phase_next         = PH_HUNT;
                        byte_count_next    = '0;
                    end
                end
                default:
                begin
                    if (last_byte_reg == SYNC_BYTE && (b & SYNC_MASK) == SYNC_MASK)
                    begin
                        emit                 = 1'b1;
                        hdr_we               = 1'b1;
                        hdr_idx              = 3'd1;
                        res_next.out_byte    = SYNC_BYTE;
                        res_next.frame_start = 1'b1;
                        byte_count_next      = FIRST_BODY;
                        phase_next           = PH_FRAME;
                    end
                end
            endcase
        end
        if (put_fields)
        begin
            res_next.profile         = hdr_reg[2][7:6];
            res_next.rate_index      = hdr_reg[2][5:2];
            res_next.sample_rate     = rate_of(hdr_reg[2][5:2]);
            res_next.channels        = {hdr_reg[2][0], hdr_reg[3][7:6]};
            res_next.crc_absent      = hdr_reg[1][0];
            res_next.frame_length    = dec_len;
            res_next.buffer_fullness = {hdr_reg[5][4:0], h6[7:2]};
            res_next.raw_blocks      = h6[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            last_byte_reg    <= '0;
            byte_count_reg   <= '0;
            total_length_reg <= '0;
            max_len_reg      <= MAX_LEN_RST;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            last_byte_reg    <= last_byte_next;
            byte_count_reg   <= byte_count_next;
            total_length_reg <= total_length_next;
            if (cfg.valid)
            begin
                max_len_reg <= cfg.max_frame_length;
            end
            if (accept)
            begin
                res_valid_reg <= emit;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // header store and result payload: no reset
    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= 6; k++)
        begin
            if (hdr_we && hdr_idx == 3'(k))
            begin
                hdr_reg[k] <= b;
            end
        end
        if (accept && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.out_byte        = res_reg.out_byte;
    assign result.frame_start     = res_reg.frame_start;
    assign result.frame_end       = res_reg.frame_end;
    assign result.length_error    = res_reg.length_error;
    assign result.profile         = res_reg.profile;
    assign result.rate_index      = res_reg.rate_index;
    assign result.sample_rate     = res_reg.sample_rate;
    assign result.channels        = res_reg.channels;
    assign result.crc_absent      = res_reg.crc_absent;
    assign result.frame_length    = res_reg.frame_length;
    assign result.buffer_fullness = res_reg.buffer_fullness;
    assign result.raw_blocks      = res_reg.raw_blocks;

endmodule

FILE: hw/rtl/adts_checker.sv
// ----------------------------------------------------------------------------
// ADTS deframer checker
// Port-level assertions on the result channel, bound to the deframer.
// ----------------------------------------------------------------------------
module adts_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid,
    input  logic                        ready,
    input  logic [adts_pkg::BYTE_W-1:0] out_byte,
    input  logic                        frame_start,
    input  logic                        frame_end,
    input  logic                        length_error,
    input  logic [1:0]                  profile,
    input  logic [adts_pkg::RATE_W-1:0] sample_rate,
    input  logic [adts_pkg::LEN_W-1:0]  frame_length,
    input  logic [10:0]                 buffer_fullness
);
    import adts_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result word dropped while stalled");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(out_byte) && $stable(frame_end))
        else $error("stalled result word changed");

    a_err_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid && length_error |-> frame_end)
        else $error("length error without frame end");

    a_start_word: assert property (@(posedge clk) disable iff (!rst_n)
        valid && frame_start |-> out_byte == SYNC_BYTE && !frame_end)
        else $error("frame start not on sync word");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !frame_end |->
        frame_length == '0 && sample_rate == '0 &&
        profile == '0 && buffer_fullness == '0)
        else $error("header fields set off the end word");

endmodule

bind adts_frame_deframer adts_checker u_adts_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid           (result.valid),
    .ready           (result.ready),
    .out_byte        (result.out_byte),
    .frame_start     (result.frame_start),
    .frame_end       (result.frame_end),
    .length_error    (result.length_error),
    .profile         (result.profile),
    .sample_rate     (result.sample_rate),
    .frame_length    (result.frame_length),
    .buffer_fullness (result.buffer_fullness)
);
